@@ rtl/sorted_key_table_top_defines.svh @@
// Assertion macros shared by the sorted key table checker.
// Every macro expects signals named clk and arst_n in the scope where it is used.
`ifndef SORTED_KEY_TABLE_TOP_DEFINES_SVH
`define SORTED_KEY_TABLE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SKT_ASSERT_NOW(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SKT_ASSERT_NEXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/skt_pkg.sv @@
// Shared constants for the sorted key table: default sizes, opcodes, status codes.
// No dependencies.
`default_nettype none

package skt_pkg;

	localparam int DEF_TABLE_DEPTH = 64;
	localparam int DEF_KEY_BITS    = 32;

	localparam int OPCODE_W = 2;
	localparam int STATUS_W = 3;

	// opcodes
	localparam logic [OPCODE_W-1:0] OP_INSERT  = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_FIND    = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_DEL_KEY = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_DEL_POS = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd4;

endpackage

`default_nettype wire

@@ rtl/sorted_key_table_top.sv @@
// Sorted key table: ascending unique keys in one synchronous memory, with a count.
// Depends on skt_pkg.
`default_nettype none

// Channel | Direction | Handshake          | Payload
// input   | in        | in_valid/in_ready   | opcode, key, position
// result  | out       | out_valid/out_ready | status, index, key_out, entries_held
//
// One item at a time. The idle state accepts it; a search runs a read state and a compare
// state for each probe, at most clog2(TABLE_DEPTH)+1 probes, then a decision state. Delete
// by position skips the search and reads and captures the removed key instead.
// Each shifted entry takes a read and a write state; insert then places the key in a put state.
// The done state loads the output register; a stalled result holds the block there.
// Reset clears the state, the count and out_valid; the key memory needs no clearing pass.

module sorted_key_table_top import skt_pkg::*; #(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int KEY_BITS    = DEF_KEY_BITS,
	localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [OPCODE_W-1:0] opcode,
	input  wire logic [KEY_BITS-1:0] key,
	input  wire logic [CNT_W-1:0]    position,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [STATUS_W-1:0]      status,
	output logic [CNT_W-1:0]         index,
	output logic [KEY_BITS-1:0]      key_out,
	output logic [CNT_W-1:0]         entries_held
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
	localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_SRD  = 9'b000000010,
		S_SCMP = 9'b000000100,
		S_KRD  = 9'b000001000,
		S_KCAP = 9'b000010000,
		S_MRD  = 9'b000100000,
		S_MWR  = 9'b001000000,
		S_PUT  = 9'b010000000,
		S_DONE = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	// key memory
	logic [KEY_BITS-1:0] mem [TABLE_DEPTH];
	logic                rd_en, wr_en;
	logic [AW-1:0]       rd_addr, wr_addr;
	logic [KEY_BITS-1:0] wr_data, rd_q;

	// item and search registers
	logic [OPCODE_W-1:0] op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [CNT_W-1:0]    pos_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    lo_q, hi_q;
	logic                hit_q;
	logic [AW-1:0]       mid_q, s_q, src_q, end_q;
	logic                up_q;

	// result held until the output register is free
	logic [STATUS_W-1:0] res_st_q;
	logic [CNT_W-1:0]    res_idx_q;
	logic [KEY_BITS-1:0] res_key_q;

	// output register
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [CNT_W-1:0]    index_q;
	logic [KEY_BITS-1:0] key_out_q;
	logic [CNT_W-1:0]    held_q;

	logic [CNT_W:0]   mid_sum;
	logic [CNT_W-1:0] mid_full;
	logic [CNT_W-1:0] lo_inc;
	logic             in_fire, out_load;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_full = mid_sum[CNT_W:1];
	assign lo_inc   = lo_q + ONE_C;

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = src_q;
		wr_en   = 1'b0;
		wr_addr = s_q;
		wr_data = key_q;
		unique case (state_q)
			S_SRD: begin
				rd_en   = (lo_q < hi_q);
				rd_addr = mid_full[AW-1:0];
			end
			S_KRD: begin
				rd_en   = 1'b1;
				rd_addr = s_q;
			end
			S_MRD: begin
				rd_en   = 1'b1;
				rd_addr = src_q;
			end
			S_MWR: begin
				wr_en   = 1'b1;
				wr_addr = up_q ? (src_q + AW'(1)) : (src_q - AW'(1));
				wr_data = rd_q;
			end
			S_PUT: begin
				wr_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// synchronous memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					if (opcode == OP_DEL_POS) begin
						state_d = (position == '0 || position > count_q) ? S_DONE : S_KRD;
					end else begin
						state_d = S_SRD;
					end
				end
			end
			S_SRD: begin
				if (lo_q < hi_q) begin
					state_d = S_SCMP;
				end else begin
					priority if (op_q == OP_INSERT && !hit_q && count_q != DEPTH_C) begin
						state_d = (count_q > lo_q) ? S_MRD : S_PUT;
					end else if (op_q == OP_DEL_KEY && hit_q && lo_inc < count_q) begin
						state_d = S_MRD;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_SCMP: state_d = S_SRD;
			S_KRD:  state_d = S_KCAP;
			S_KCAP: state_d = (pos_q < count_q) ? S_MRD : S_DONE;
			S_MRD:  state_d = S_MWR;
			S_MWR: begin
				if (src_q == end_q) begin
					state_d = up_q ? S_PUT : S_DONE;
				end else begin
					state_d = S_MRD;
				end
			end
			S_PUT:  state_d = S_DONE;
			S_DONE: state_d = out_load ? S_IDLE : S_DONE;
			default: state_d = S_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// count moves at the decision point, before entries shift
			if (state_q == S_SRD && lo_q >= hi_q) begin
				if (op_q == OP_INSERT && !hit_q && count_q != DEPTH_C) begin
					count_q <= count_q + ONE_C;
				end else if (op_q == OP_DEL_KEY && hit_q) begin
					count_q <= count_q - ONE_C;
				end
			end
			if (state_q == S_KCAP) begin
				count_q <= count_q - ONE_C;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item, search, shift and result registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					op_q      <= opcode;
					key_q     <= key;
					pos_q     <= position;
					lo_q      <= '0;
					hi_q      <= count_q;
					hit_q     <= 1'b0;
					s_q       <= AW'(position - ONE_C);
					res_st_q  <= ST_BADPOS;
					res_idx_q <= '0;
					res_key_q <= '0;
				end
			end
			S_SRD: begin
				mid_q <= mid_full[AW-1:0];
				if (lo_q >= hi_q) begin
					s_q       <= AW'(lo_q);
					res_idx_q <= '0;
					res_key_q <= '0;
					// shift bounds use the count before this item
					if (op_q == OP_INSERT) begin
						up_q  <= 1'b1;
						src_q <= AW'(count_q - ONE_C);
						end_q <= AW'(lo_q);
					end else begin
						up_q  <= 1'b0;
						src_q <= AW'(lo_inc);
						end_q <= AW'(count_q - ONE_C);
					end
					priority if (hit_q) begin
						res_st_q  <= (op_q == OP_INSERT) ? ST_PRESENT : ST_DONE;
						res_idx_q <= lo_inc;
						res_key_q <= key_q;
					end else if (op_q == OP_INSERT && count_q == DEPTH_C) begin
						res_st_q <= ST_FULL;
					end else if (op_q == OP_INSERT) begin
						res_st_q  <= ST_DONE;
						res_idx_q <= lo_inc;
					end else begin
						res_st_q <= ST_NOTFOUND;
					end
				end
			end
			S_SCMP: begin
				// lower bound: first entry not below the key
				if (rd_q < key_q) begin
					lo_q <= CNT_W'(mid_q) + ONE_C;
				end else begin
					hi_q <= CNT_W'(mid_q);
				end
				if (rd_q == key_q) begin
					hit_q <= 1'b1;
				end
			end
			S_KCAP: begin
				res_st_q  <= ST_DONE;
				res_idx_q <= pos_q;
				res_key_q <= rd_q;
				up_q      <= 1'b0;
				src_q     <= AW'(pos_q);
				end_q     <= AW'(count_q - ONE_C);
			end
			S_MWR: begin
				if (src_q != end_q) begin
					src_q <= up_q ? (src_q - AW'(1)) : (src_q + AW'(1));
				end
			end
			S_DONE: begin
				if (out_load) begin
					status_q  <= res_st_q;
					index_q   <= res_idx_q;
					key_out_q <= res_key_q;
					held_q    <= count_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign index        = index_q;
	assign key_out      = key_out_q;
	assign entries_held = held_q;

endmodule

`default_nettype wire

@@ rtl/skt_checker.sv @@
// Port-level checker for the sorted key table, bound to the top level.
// Depends on skt_pkg and sorted_key_table_top_defines.svh.
`default_nettype none

`include "sorted_key_table_top_defines.svh"

module skt_checker import skt_pkg::*; #(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int KEY_BITS    = DEF_KEY_BITS,
	localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire logic [OPCODE_W-1:0] opcode,
	input wire logic [KEY_BITS-1:0] key,
	input wire logic [CNT_W-1:0]    position,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire logic [STATUS_W-1:0] status,
	input wire logic [CNT_W-1:0]    index,
	input wire logic [KEY_BITS-1:0] key_out,
	input wire logic [CNT_W-1:0]    entries_held
);

	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

	logic                                 fail_item, no_entry, index_ok;
	logic                                 in_stall, out_stall;
	logic [OPCODE_W+KEY_BITS+CNT_W-1:0]   in_word;
	logic [STATUS_W+2*CNT_W+KEY_BITS-1:0] out_word;

	assign fail_item = (status == ST_NOTFOUND) || (status == ST_FULL) ||
		(status == ST_BADPOS);
	assign no_entry  = (index == '0) && (key_out == '0);
	assign index_ok  = (index <= DEPTH_C) &&
		(status == ST_PRESENT || index <= entries_held + CNT_W'(1));
	assign in_stall  = in_valid && !in_ready;
	assign out_stall = out_valid && !out_ready;
	assign in_word   = {opcode, key, position};
	assign out_word  = {status, index, key_out, entries_held};

	// a failed item names no entry and no key
	`SKT_ASSERT_NOW(a_fail_empty, out_valid && fail_item, no_entry, "failed item carries index or key")

	// a present or done item with a position names one inside the table
	`SKT_ASSERT_NOW(a_index_range, out_valid && index != '0, index_ok, "index outside the table")

	// the table never holds more than its depth
	`SKT_ASSERT_NOW(a_held_range, out_valid, entries_held <= DEPTH_C, "entry count beyond depth")

	// a stalled result stays offered
	`SKT_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_word), "stalled result changed")

	// a waiting input item stays offered
	`SKT_ASSERT_NEXT(a_in_hold, in_stall, in_valid && $stable(in_word), "waiting input item changed")

endmodule

bind sorted_key_table_top skt_checker #(
	.TABLE_DEPTH(TABLE_DEPTH),
	.KEY_BITS(KEY_BITS)
) u_skt_checker (.*);

`default_nettype wire
